### hw/rtl/mlp_inference_classifier_unit_macros.svh
// Assertion macros used by the classifier back end (mlp_ic_back).
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef MLP_INFERENCE_CLASSIFIER_UNIT_MACROS_SVH
`define MLP_INFERENCE_CLASSIFIER_UNIT_MACROS_SVH

// Plain property, checked every clock out of reset
`define MLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define MLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mlp_ic_pkg.sv
// Package for the MLP classifier: beat types, config struct, constants,
// activation tables and arithmetic helpers. No dependencies.
package mlp_ic_pkg;

  // Default sizing
  localparam int MAX_INPUTS_DEF   = 16;
  localparam int HIDDEN_NODES_DEF = 8;
  localparam int MAX_LAYERS_DEF   = 4;
  localparam int MAX_CLASSES_DEF  = 8;
  localparam int QUEUE_DEPTH      = 2;

  // Activation modes
  localparam logic [1:0] ACT_SIGMOID = 2'd0;
  localparam logic [1:0] ACT_TANH    = 2'd1;
  localparam logic [1:0] ACT_RELU    = 2'd2;

  // Config register indexes
  localparam logic [1:0] CFG_ACT     = 2'd0;
  localparam logic [1:0] CFG_INPUTS  = 2'd1;
  localparam logic [1:0] CFG_LAYERS  = 2'd2;
  localparam logic [1:0] CFG_CLASSES = 2'd3;

  // Input opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  localparam int ACC_W = 58;
  localparam logic signed [ACC_W-1:0] ACC_LIM = 58'sh100000000000000;
  localparam logic signed [ACC_W-1:0] S32_MAX = 58'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -58'sd2147483648;
  localparam logic [63:0] EXP_STEP = 64'd4034748382;

  typedef struct packed {
    logic              op;
    logic [8:0]        weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature;
    logic [2:0]        label;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         predicted_class;
    logic               label_match;
    logic signed [31:0] best_score;
    logic [31:0]        correct_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] activation_mode;
    logic [4:0] input_count;
    logic [2:0] layer_count;
    logic [3:0] class_count;
  } cfg_t;

  typedef enum logic [1:0] {
    K_WRITE,
    K_FEAT,
    K_LAST
  } cmd_kind_e;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_kind_e          kind;
    logic [8:0]         addr;
    logic signed [15:0] data;
    logic [2:0]         label;
  } cmd_t;

  typedef logic signed [31:0] act_tab_t [256];

  // Shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid or tanh table in Q16.16, entry i at x = (i-128)/16
  function automatic act_tab_t build_tab(input logic tanh_sel);
    logic [63:0] pw [257];
    act_tab_t    t;
    logic [63:0] e, e2, d, d2, s, v;
    int          k, m;
    pw[0] = 64'h1_0000_0000;
    pw[1] = EXP_STEP;
    for (int p = 2; p <= 256; p++) begin
      pw[p] = (pw[p-1] * EXP_STEP + 64'h8000_0000) >> 32;
    end
    for (int i = 0; i < 256; i++) begin
      k  = i - 128;
      m  = (k < 0) ? -k : k;
      e  = pw[m];
      e2 = pw[2*m];
      d  = 64'h1_0000_0000 + e;
      d2 = 64'h1_0000_0000 + e2;
      s  = udiv64(64'h1_0000_0000_0000 + (d >> 1), d);
      v  = udiv64((64'h1_0000_0000 - e2) * 64'd65536 + (d2 >> 1), d2);
      if (tanh_sel) begin
        t[i] = (k < 0) ? -32'(v) : 32'(v);
      end else begin
        t[i] = (k < 0) ? 32'(64'd65536 - s) : 32'(s);
      end
    end
    return t;
  endfunction

  localparam act_tab_t SIG_TAB  = build_tab(1'b0);
  localparam act_tab_t TANH_TAB = build_tab(1'b1);

  // Selected activation of a Q16.16 value
  function automatic logic signed [31:0] activate(input logic signed [31:0] x,
                                                  input logic [1:0] mode);
    logic [7:0]         idx;
    logic signed [31:0] sh;
    sh  = x + 32'sd524288;
    idx = sh[19:12];
    if (x < -32'sd524288) begin
      idx = 8'd0;
    end else if (x >= 32'sd524288) begin
      idx = 8'd255;
    end
    if (mode == ACT_SIGMOID) begin
      return SIG_TAB[idx];
    end else if (mode == ACT_TANH) begin
      return TANH_TAB[idx];
    end
    return (x < 0) ? 32'sd0 : x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

### hw/rtl/mlp_ic_front.sv
// Front end: classifies input beats and queues them for the back end.
// Depends on mlp_ic_pkg.
module mlp_ic_front import mlp_ic_pkg::*; #(
  parameter int STORE_DEPTH = 384
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           queue_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  cmd_t           cls;
  logic           keep, push, pop;

  // Classify: out-of-range writes are dropped here
  always_comb begin
    cls.addr  = in_data_i.weight_index;
    cls.label = in_data_i.label;
    if (in_data_i.op == OP_WRITE) begin
      cls.kind = K_WRITE;
      cls.data = in_data_i.weight_value;
      keep     = (32'(in_data_i.weight_index) < STORE_DEPTH);
    end else begin
      cls.kind = in_data_i.last ? K_LAST : K_FEAT;
      cls.data = in_data_i.feature;
      keep     = 1'b1;
    end
  end

  assign in_ready_o  = (cnt_q < QCW'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Pointer update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule

### hw/rtl/mlp_ic_back.sv
// Back end: weight store, feature buffer, shared MAC sequencer, argmax and
// result register. Depends on mlp_ic_pkg and the assertion macro header.
`include "mlp_inference_classifier_unit_macros.svh"
module mlp_ic_back import mlp_ic_pkg::*; #(
  parameter int MAX_INPUTS   = MAX_INPUTS_DEF,
  parameter int HIDDEN_NODES = HIDDEN_NODES_DEF,
  parameter int MAX_LAYERS   = MAX_LAYERS_DEF,
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int H        = HIDDEN_NODES;
  localparam int HID_BASE = MAX_INPUTS * H;
  localparam int OUT_BASE = HID_BASE + (MAX_LAYERS - 1) * H * H;
  localparam int WS_DEPTH = OUT_BASE + H * MAX_CLASSES;
  localparam int AW       = $clog2(WS_DEPTH);
  localparam int PW       = $clog2(MAX_INPUTS + 1);
  localparam int FIW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HIW      = (H > 1) ? $clog2(H) : 1;
  localparam int JMAX     = (MAX_INPUTS > H) ? MAX_INPUTS : H;
  localparam int JW       = $clog2(JMAX + 1);
  localparam int KMAX     = (MAX_CLASSES > H) ? MAX_CLASSES : H;
  localparam int KW       = $clog2(KMAX + 1);
  localparam int SW       = $clog2(MAX_LAYERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_MUL,
    S_ACC,
    S_NODE,
    S_OUT
  } state_e;

  state_e                    state_q;
  logic signed [15:0]        mem [WS_DEPTH];
  logic signed [15:0]        fbuf_q [MAX_INPUTS];
  logic signed [31:0]        lv_q [H];
  logic signed [31:0]        nx_q [H];
  logic [PW-1:0]             pos_q;
  logic [PW-1:0]             used_q;
  logic [SW-1:0]             layers_q, stage_q;
  logic [KW-1:0]             classes_q, k_q;
  logic [JW-1:0]             j_q;
  logic [2:0]                label_q, best_c_q;
  logic signed [31:0]        best_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [15:0]        rdata_q;
  logic signed [31:0]        op_a_q;
  logic signed [47:0]        prod_q;
  logic [31:0]               match_total_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic [JW-1:0]             jlim;
  logic [KW-1:0]             klim;
  logic [AW-1:0]             raddr;
  logic signed [47:0]        mult;
  logic signed [ACC_W-1:0]   acc_sum, acc_clamped;
  logic signed [31:0]        net;
  logic                      out_free, last_node, match;
  logic [31:0]               total_next;
  logic [PW-1:0]             pos_next;
  int                        used_i, lc_i, cc_i, pos_i;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Loop limits for the current layer
  assign jlim      = (stage_q == '0) ? JW'(used_q) : JW'(H);
  assign klim      = (stage_q == layers_q) ? classes_q : KW'(H);
  assign last_node = ((k_q + 1'b1) >= klim);

  // Weight address for (stage, j, k)
  always_comb begin
    if (stage_q == '0) begin
      raddr = AW'(32'(j_q) * H + 32'(k_q));
    end else if (stage_q == layers_q) begin
      raddr = AW'(OUT_BASE + 32'(j_q) * MAX_CLASSES + 32'(k_q));
    end else begin
      raddr = AW'(HID_BASE + (32'(stage_q) - 1) * H * H + 32'(j_q) * H + 32'(k_q));
    end
  end

  // MAC datapath
  assign mult = op_a_q * rdata_q;
  always_comb begin
    acc_sum = acc_q + ACC_W'(prod_q);
    if (acc_sum > ACC_LIM) begin
      acc_clamped = ACC_LIM;
    end else if (acc_sum < -ACC_LIM) begin
      acc_clamped = -ACC_LIM;
    end else begin
      acc_clamped = acc_sum;
    end
  end
  assign net = sat32(acc_q);

  // Sample setup figures, taken on the last feature
  always_comb begin
    pos_i    = int'(pos_q) + ((int'(pos_q) < MAX_INPUTS) ? 1 : 0);
    pos_next = PW'(pos_i);
    used_i   = (int'(cfg_i.input_count) < MAX_INPUTS) ? int'(cfg_i.input_count) : MAX_INPUTS;
    if (used_i > pos_i) begin
      used_i = pos_i;
    end
    lc_i = (cfg_i.layer_count == '0) ? 1 : int'(cfg_i.layer_count);
    if (lc_i > MAX_LAYERS) begin
      lc_i = MAX_LAYERS;
    end
    cc_i = (cfg_i.class_count == '0) ? 1 : int'(cfg_i.class_count);
    if (cc_i > MAX_CLASSES) begin
      cc_i = MAX_CLASSES;
    end
  end

  assign match      = (label_q == best_c_q);
  assign total_next = (match && match_total_q != 32'hffff_ffff) ?
                      match_total_q + 32'd1 : match_total_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q         <= '0;
      used_q        <= '0;
      layers_q      <= SW'(1);
      classes_q     <= KW'(1);
      stage_q       <= '0;
      k_q           <= '0;
      j_q           <= '0;
      label_q       <= '0;
      best_c_q      <= '0;
      best_q        <= '0;
      acc_q         <= '0;
      op_a_q        <= '0;
      prod_q        <= '0;
      match_total_q <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      for (int i = 0; i < H; i++) begin
        lv_q[i] <= '0;
        nx_q[i] <= '0;
      end
    end else begin
      // S_OUT reloads the register itself when the old beat leaves
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_i.kind != K_WRITE) begin
            pos_q <= pos_next;
            if (cmd_i.kind == K_LAST) begin
              label_q   <= cmd_i.label;
              used_q    <= PW'(used_i);
              layers_q  <= SW'(lc_i);
              classes_q <= KW'(cc_i);
              stage_q   <= '0;
              k_q       <= '0;
              j_q       <= '0;
              acc_q     <= '0;
              state_q   <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (j_q >= jlim) begin
            state_q <= S_NODE;
          end else begin
            if (stage_q == '0) begin
              op_a_q <= 32'(fbuf_q[j_q[FIW-1:0]]);
            end else begin
              op_a_q <= activate(lv_q[j_q[HIW-1:0]], cfg_i.activation_mode);
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= (stage_q == '0) ? mult : (mult >>> 8);
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_clamped;
          j_q     <= j_q + 1'b1;
          state_q <= S_ADDR;
        end
        S_NODE: begin
          acc_q <= '0;
          j_q   <= '0;
          k_q   <= last_node ? '0 : k_q + 1'b1;
          if (stage_q != layers_q) begin
            nx_q[k_q[HIW-1:0]] <= net;
            if (last_node) begin
              for (int i = 0; i < H; i++) begin
                lv_q[i] <= (HIW'(i) == k_q[HIW-1:0]) ? net : nx_q[i];
              end
              stage_q <= stage_q + 1'b1;
            end
            state_q <= S_ADDR;
          end else begin
            if (k_q == '0 || net > best_q) begin
              best_q   <= net;
              best_c_q <= 3'(k_q);
            end
            state_q <= last_node ? S_OUT : S_ADDR;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_q.predicted_class <= best_c_q;
            out_q.label_match     <= match;
            out_q.best_score      <= best_q;
            out_q.correct_count   <= total_next;
            match_total_q         <= total_next;
            pos_q                 <= '0;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Weight store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.kind == K_WRITE) begin
      mem[AW'(cmd_i.addr)] <= cmd_i.data;
    end
    if (state_q == S_ADDR) begin
      rdata_q <= mem[raddr];
    end
  end

  // Feature buffer
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.kind != K_WRITE &&
        int'(pos_q) < MAX_INPUTS) begin
      fbuf_q[pos_q[FIW-1:0]] <= cmd_i.data;
    end
  end

  // Checks
  `MLP_ASSERT_IMP(a_j_bound, state_q == S_MUL, j_q < jlim, "MAC index past layer width")
  `MLP_ASSERT_IMP(a_stage_bound, state_q != S_IDLE, stage_q <= layers_q, "stage past output layer")
  `MLP_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, out_valid_q && state_q == S_IDLE, "result not loaded")
  `MLP_ASSERT(a_count_mono, match_total_q >= $past(match_total_q), "correct count went down")

endmodule

### hw/rtl/mlp_inference_classifier_unit.sv
// MLP classifier top. Weight write beat: queued in the front end, then written to the store
// once the back end idles. Sample: each of the used*H + (L-1)*H*H + C*H MACs runs S_ADDR,
// S_MUL, S_ACC and each of the L*H + C nodes S_ADDR, S_NODE on one MAC, then S_OUT.
// One sample at a time; the next beat leaves the 2-entry queue once the back end idles.
// Reset (async, active low) clears config to defaults, counters and the count;
// weight store and feature buffer hold nothing defined until written.
module mlp_inference_classifier_unit import mlp_ic_pkg::*; #(
  parameter int MAX_INPUTS   = MAX_INPUTS_DEF,
  parameter int HIDDEN_NODES = HIDDEN_NODES_DEF,
  parameter int MAX_LAYERS   = MAX_LAYERS_DEF,
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int STORE_DEPTH = MAX_INPUTS * HIDDEN_NODES +
                               (MAX_LAYERS - 1) * HIDDEN_NODES * HIDDEN_NODES +
                               HIDDEN_NODES * MAX_CLASSES;

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Config registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.activation_mode <= ACT_SIGMOID;
      cfg_q.input_count     <= 5'd16;
      cfg_q.layer_count     <= 3'd1;
      cfg_q.class_count     <= 4'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ACT:     cfg_q.activation_mode <= cfg_data_i[1:0];
        CFG_INPUTS:  cfg_q.input_count     <= cfg_data_i[4:0];
        CFG_LAYERS:  cfg_q.layer_count     <= cfg_data_i[2:0];
        CFG_CLASSES: cfg_q.class_count     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  mlp_ic_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  mlp_ic_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .HIDDEN_NODES(HIDDEN_NODES),
    .MAX_LAYERS  (MAX_LAYERS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### tb/mlp_ic_checker.sv
// Scoreboard for the MLP classifier: watches the input, config and result channels,
// predicts each classification in 64-bit integer math and compares field by field.
// Depends on mlp_ic_pkg for the beat types and code constants.
`timescale 1ns / 1ps

module mlp_ic_checker import mlp_ic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int        pending_o,
  output int        fails_o
);

  localparam int    NODES     = 8;
  localparam int    FEAT_MAX  = 16;
  localparam int    LAYER_MAX = 4;
  localparam int    CLASS_MAX = 8;
  localparam int    HID_OFS   = 128;
  localparam int    OUT_OFS   = 320;
  localparam int    STORE_SZ  = 384;
  localparam longint SUM_CLAMP = 64'sd1 <<< 56;

  longint    sig_lut [256];
  longint    tanh_lut [256];
  longint    weights [STORE_SZ];
  longint    feats [FEAT_MAX];
  longint    hidden [NODES];
  int        feat_pos;
  logic [31:0] match_cnt;
  logic [1:0] act_mode;
  logic [4:0] n_inputs;
  logic [2:0] n_layers;
  logic [3:0] n_classes;
  out_item_t predicted_q [$];

  // Sigmoid and tanh tables, entry i at x = (i-128)/16, Q16.16
  initial begin
    longint unsigned pw [257];
    longint unsigned e, e2, d, d2, s, t;
    int k, m;
    pw[0] = 64'h1_0000_0000;
    pw[1] = 64'd4034748382;
    for (int p = 2; p <= 256; p++) begin
      pw[p] = (pw[p-1] * pw[1] + 64'h8000_0000) >> 32;
    end
    for (int i = 0; i < 256; i++) begin
      k  = i - 128;
      m  = (k < 0) ? -k : k;
      e  = pw[m];
      e2 = pw[2*m];
      d  = 64'h1_0000_0000 + e;
      d2 = 64'h1_0000_0000 + e2;
      s  = (64'h1_0000_0000_0000 + (d >> 1)) / d;
      t  = ((64'h1_0000_0000 - e2) * 64'd65536 + (d2 >> 1)) / d2;
      sig_lut[i]  = (k < 0) ? 65536 - longint'(s) : longint'(s);
      tanh_lut[i] = (k < 0) ? -longint'(t) : longint'(t);
    end
  end

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_CLAMP) s = SUM_CLAMP;
    if (s < -SUM_CLAMP) s = -SUM_CLAMP;
    return s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint squash(longint x);
    int idx;
    if (act_mode != ACT_SIGMOID && act_mode != ACT_TANH) begin
      return (x < 0) ? 0 : x;
    end
    if (x < -524288) idx = 0;
    else if (x >= 524288) idx = 255;
    else idx = int'((x + 524288) >>> 12);
    return (act_mode == ACT_SIGMOID) ? sig_lut[idx] : tanh_lut[idx];
  endfunction

  // Full forward pass plus argmax for the sample just closed
  function automatic out_item_t classify(logic [2:0] label);
    longint    acc, best;
    longint    nxt [NODES];
    int        used, layers, classes, best_c, base;
    out_item_t r;
    used    = (n_inputs < FEAT_MAX) ? n_inputs : FEAT_MAX;
    if (used > feat_pos) used = feat_pos;
    layers  = (n_layers < 1) ? 1 : ((n_layers > LAYER_MAX) ? LAYER_MAX : n_layers);
    classes = (n_classes < 1) ? 1 : ((n_classes > CLASS_MAX) ? CLASS_MAX : n_classes);
    for (int k = 0; k < NODES; k++) begin
      acc = 0;
      for (int j = 0; j < used; j++) acc = clamp_add(acc, feats[j] * weights[j*NODES+k]);
      hidden[k] = clip32(acc);
    end
    for (int l = 1; l < layers; l++) begin
      base = HID_OFS + (l - 1) * NODES * NODES;
      for (int k = 0; k < NODES; k++) begin
        acc = 0;
        for (int j = 0; j < NODES; j++) begin
          acc = clamp_add(acc, (squash(hidden[j]) * weights[base + j*NODES + k]) >>> 8);
        end
        nxt[k] = clip32(acc);
      end
      for (int k = 0; k < NODES; k++) hidden[k] = nxt[k];
    end
    best   = 0;
    best_c = 0;
    for (int c = 0; c < classes; c++) begin
      acc = 0;
      for (int j = 0; j < NODES; j++) begin
        acc = clamp_add(acc, (squash(hidden[j]) * weights[OUT_OFS + j*CLASS_MAX + c]) >>> 8);
      end
      acc = clip32(acc);
      if (c == 0 || acc > best) begin
        best   = acc;
        best_c = c;
      end
    end
    r.predicted_class = best_c[2:0];
    r.label_match     = (label == best_c[2:0]);
    if (r.label_match && match_cnt != 32'hffff_ffff) match_cnt++;
    r.best_score      = best[31:0];
    r.correct_count   = match_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (fails_o < 40) $display("mismatch %s: got %0d, want %0d", what, got, want);
    fails_o++;
  endtask

  // Track beats on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      act_mode  = ACT_SIGMOID;
      n_inputs  = 5'd16;
      n_layers  = 3'd1;
      n_classes = 4'd2;
      feat_pos  = 0;
      match_cnt = '0;
      fails_o   = 0;
      for (int k = 0; k < NODES; k++) hidden[k] = 0;
      predicted_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ACT:     act_mode  = cfg_data_i[1:0];
          CFG_INPUTS:  n_inputs  = cfg_data_i[4:0];
          CFG_LAYERS:  n_layers  = cfg_data_i[2:0];
          default:     n_classes = cfg_data_i[3:0];
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.op == OP_WRITE) begin
          if (in_data_i.weight_index < STORE_SZ) begin
            weights[in_data_i.weight_index] = longint'(in_data_i.weight_value);
          end
        end else begin
          if (feat_pos < FEAT_MAX) begin
            feats[feat_pos] = longint'(in_data_i.feature);
            feat_pos++;
          end
          if (in_data_i.last) begin
            predicted_q.push_back(classify(in_data_i.label));
            feat_pos = 0;
          end
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("unexpected result, class", out_data_i.predicted_class, -1);
        end else begin
          want = predicted_q.pop_front();
          if (out_data_i.predicted_class != want.predicted_class)
            report_mismatch("predicted_class", out_data_i.predicted_class,
                            want.predicted_class);
          if (out_data_i.label_match != want.label_match)
            report_mismatch("label_match", out_data_i.label_match, want.label_match);
          if (out_data_i.best_score != want.best_score)
            report_mismatch("best_score", out_data_i.best_score, want.best_score);
          if (out_data_i.correct_count != want.correct_count)
            report_mismatch("correct_count", out_data_i.correct_count, want.correct_count);
        end
      end
    end
    pending_o = predicted_q.size();
  end

endmodule

### tb/tb.sv
// Top of the MLP classifier testbench: clock, reset, stimulus and verdict.
// Depends on mlp_ic_pkg, mlp_inference_classifier_unit and mlp_ic_checker.
`timescale 1ns / 1ps

module tb import mlp_ic_pkg::*;;

  localparam logic [1:0] ACT_ALT_RELU = 2'd3;  // undefined mode, behaves as relu
  localparam int SETTLE_CYCLES = 1300;         // worst sample latency with margin
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int STORE_SZ      = 384;
  localparam int N_PHASES      = 7;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  int         pending;
  int         fails;
  int         cycles;
  bit         no_idle;
  bit         hold_req;

  mlp_inference_classifier_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mlp_ic_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fails_o(fails)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        held = 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // One input beat, with an optional idle burst ahead of it
  task automatic send(in_item_t it);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_weight(int idx, logic [15:0] val);
    in_item_t it;
    it              = '0;
    it.op           = OP_WRITE;
    it.weight_index = idx[8:0];
    it.weight_value = val;
    it.feature      = 16'($urandom);
    it.label        = 3'($urandom);
    it.last         = 1'($urandom);
    send(it);
  endtask

  // One sample of n features; wide picks full-range values
  task automatic send_sample(int n, logic [2:0] label, bit wide);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it              = '0;
      it.op           = OP_FEATURE;
      it.weight_index = 9'($urandom);
      it.weight_value = 16'($urandom);
      it.feature      = wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
      it.label        = (i == n - 1) ? label : 3'($urandom);
      it.last         = (i == n - 1);
      send(it);
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending, wait for every result, then let a weight write settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0] modes   [N_PHASES] = '{ACT_RELU, ACT_SIGMOID, ACT_TANH, ACT_ALT_RELU,
                                       ACT_TANH, ACT_SIGMOID, ACT_RELU};
    logic [7:0] inputs  [N_PHASES] = '{8'd4, 8'd16, 8'd1, 8'd0, 8'd20, 8'd8, 8'd16};
    logic [7:0] layers  [N_PHASES] = '{8'd2, 8'd4, 8'd1, 8'd0, 8'd7, 8'd3, 8'd4};
    logic [7:0] classes [N_PHASES] = '{8'd4, 8'd8, 8'd1, 8'd0, 8'd15, 8'd5, 8'd8};
    int sent, n, lim;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ACT;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole store so no sample reads an unwritten entry
    for (int i = 0; i < STORE_SZ; i++) write_weight(i, 16'($urandom_range(0, 1023) - 512));

    // Directed: reset config, extreme weights and features, odd sample shapes
    write_weight(0, 16'h7fff);
    write_weight(8, 16'h8000);
    write_weight(320, 16'h7fff);
    write_weight(383, 16'h8000);
    write_weight(511, 16'h1234);   // out of range, ignored
    write_weight(384, 16'hffff);   // out of range, ignored
    send_sample(16, 3'd1, 1'b1);   // full sample, extreme values
    send_sample(3, 3'd0, 1'b0);    // short sample
    send_sample(20, 3'd1, 1'b1);   // extra features dropped
    send_sample(1, 3'd7, 1'b0);    // label beyond class count
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_cfg(CFG_ACT, {6'($urandom), modes[p]});
      write_cfg(CFG_INPUTS, inputs[p]);
      write_cfg(CFG_LAYERS, layers[p]);
      write_cfg(CFG_CLASSES, classes[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == N_PHASES - 1) no_idle = 1'b1;
      lim  = (inputs[p] == 0 || inputs[p] > 16) ? 16 : inputs[p];
      sent = 0;
      while (sent < 32) begin
        if ($urandom_range(0, 9) == 0) begin
          // weight refresh as noise, occasionally out of range
          write_weight($urandom_range(0, 511), 16'($urandom));
          sent++;
        end else begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(1, lim);
          send_sample(n, 3'($urandom), $urandom_range(0, 2) == 0);
          sent += n;
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mlp_ic_pkg.sv
hw/rtl/mlp_ic_front.sv
hw/rtl/mlp_ic_back.sv
hw/rtl/mlp_inference_classifier_unit.sv
tb/mlp_ic_checker.sv
tb/tb.sv
